[hdl/segh_pkg.sv]
// ============================================================================
// Spring element package
// Shared widths, codes, index tables and saturation helpers of the spring
// energy, gradient and Hessian core.
// ============================================================================
package segh_pkg;

    localparam int DMAG_W   = 32;   // magnitude of one coordinate difference
    localparam int LEN_W    = 33;   // spring length, Q16.16
    localparam int ROOT_W   = 35;   // root width inside the square root unit
    localparam int KC_W     = 48;   // k*|C| in Q16.16
    localparam int UMAG_W   = 17;   // direction component magnitude, at most 1.0
    localparam int OUT_W    = 48;
    localparam int ENERGY_W = 47;
    localparam int HESS_N   = 6;

    localparam logic [30:0] STIFFNESS_RESET = 31'd65536;
    localparam logic        REG_STIFFNESS   = 1'b0;

    localparam logic [OUT_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_MIN = 48'h8000_0000_0000;

    // Row and column of each upper-triangle Hessian entry: xx xy xz yy yz zz.
    localparam int HESS_I [HESS_N] = '{0, 0, 0, 1, 1, 2};
    localparam int HESS_J [HESS_N] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [2:0] dneg;   // sign of each coordinate difference
        logic       cneg;   // spring is compressed
        logic       deg;    // length is zero
    } segh_flags_t;

    // Sign and magnitude to a saturated 48-bit two's complement value.
    function automatic logic [OUT_W-1:0] enc48(input logic neg, input logic [OUT_W:0] mag);
        logic [OUT_W:0] lim;
        lim = mag;
        if (neg)
        begin
            if (mag > {1'b0, NEG_MIN})
            begin
                lim = {1'b0, NEG_MIN};
            end
            enc48 = OUT_W'({(OUT_W+1){1'b0}} - lim);
        end
        else
        begin
            enc48 = (mag > {1'b0, POS_MAX}) ? POS_MAX : mag[OUT_W-1:0];
        end
    endfunction

    // Saturate a signed 51-bit sum to the 48-bit range.
    function automatic logic [OUT_W-1:0] sat48(input logic signed [50:0] h);
        if (h > $signed({3'b000, POS_MAX}))
        begin
            sat48 = POS_MAX;
        end
        else if (h < $signed({3'b111, NEG_MIN}))
        begin
            sat48 = NEG_MIN;
        end
        else
        begin
            sat48 = h[OUT_W-1:0];
        end
    endfunction

endpackage

[hdl/spring_energy_gradient_hessian_core.sv]
// ============================================================================
// Spring energy, gradient and Hessian core
// One spring per beat: length, stretch, energy, node-0 gradient and the
// upper triangle of the 3x3 Hessian block, all in saturating Q16.16.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         s_tvalid / s_tready     s_tdata: p0 xyz, p1 xyz, rest length
//  m_axis    out        m_tvalid / m_tready     m_tdata: energy, gradient, Hessian;
//                                               m_tuser: degenerate
//  apb       in/out     psel, penable, pready   spring_stiffness at address 0
//
// Timing: one spring is accepted per cycle unless the output stalls. The
// pipeline has 107 register stages, from the coordinate differences to the
// output register. The depth is set by the 35-stage square root
// followed by the 17-stage direction divider and the 48-stage Hessian
// divider, which run in series. Reset clears the valid bits and sets the
// stiffness to 1.0. A stall at the output freezes the whole pipeline in
// place, so the input is refused only while the result register is full and
// not being taken; no beat is lost or repeated.
//
module spring_energy_gradient_hessian_core
    import segh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Fields from bit 0 up: first_x, first_y, first_z, second_x, second_y,
    // second_z (32 bits each), rest_length (31 bits), one zero pad bit.
    input  logic [223:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0 up: energy (47), grad_x, grad_y, grad_z, hess_xx,
    // hess_xy, hess_xz, hess_yy, hess_yz, hess_zz (48 each), one zero pad bit.
    output logic [479:0] m_tdata,
    // Fields from bit 0 up: degenerate.
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int LAT = 107;

    // ---------------------------------------------------------------- config
    logic [30:0] k_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STIFFNESS) ? {1'b0, k_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= STIFFNESS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_STIFFNESS))
        begin
            k_reg <= pwdata[30:0];
        end
    end

    // ----------------------------------------------------- flow control
    // Every stage moves together; the last stage is the output register.
    logic           en;
    logic [LAT-1:0] v_reg;

    assign en       = !v_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], s_tvalid};
        end
    end

    // ------------------------------------------- stage 1: differences
    logic [DMAG_W-1:0] dmag1_reg [3];
    logic [2:0]        dneg1_reg;
    logic [30:0]       rest1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [32:0] diff;
                diff = {s_tdata[32*i+31], s_tdata[32*i +: 32]}
                     - {s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]};
                dneg1_reg[i] <= diff[32];
                dmag1_reg[i] <= diff[32] ? DMAG_W'(33'd0 - diff) : diff[31:0];
            end
            rest1_reg <= s_tdata[222:192];
        end
    end

    // ------------------------------------- stages 2 and 3: squared length
    logic [63:0] sq2_reg [3];
    logic [65:0] s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= dmag1_reg[i] * dmag1_reg[i];
            end
            s3_reg <= {2'b00, sq2_reg[0]} + {2'b00, sq2_reg[1]} + {2'b00, sq2_reg[2]};
        end
    end

    // ------------------------------------ stages 4..38: square root
    logic [ROOT_W-1:0] root38;
    logic [129:0]      side38;
    logic [DMAG_W-1:0] dmag38 [3];
    logic [2:0]        dneg38;
    logic [30:0]       rest38;
    logic [LEN_W-1:0]  len38;

    segh_sqrt u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (s3_reg),
        .root     (root38)
    );

    segh_delay #(.W(130), .DEPTH(37)) u_dly_side
    (
        .clk  (clk),
        .en   (en),
        .din  ({dneg1_reg, dmag1_reg[2], dmag1_reg[1], dmag1_reg[0], rest1_reg}),
        .dout (side38)
    );

    assign rest38    = side38[30:0];
    assign dmag38[0] = side38[62:31];
    assign dmag38[1] = side38[94:63];
    assign dmag38[2] = side38[126:95];
    assign dneg38    = side38[129:127];
    assign len38     = root38[LEN_W-1:0];

    // ------------------------- stages 39..42: stretch, k*|C| and energy
    logic [LEN_W-1:0] cmag39_reg, cmag40_reg, len39_reg;
    segh_flags_t      flags39_reg;
    logic [KC_W-1:0]  kc40_reg;
    logic [56:0]      eh41_reg, el41_reg;
    logic [ENERGY_W-1:0] energy42_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [33:0] c;
            logic [63:0] kcp;
            logic [80:0] esum;
            c = {1'b0, len38} - {3'b000, rest38};
            cmag39_reg        <= c[33] ? LEN_W'(34'd0 - c) : c[LEN_W-1:0];
            flags39_reg.cneg  <= c[33];
            flags39_reg.dneg  <= dneg38;
            flags39_reg.deg   <= (len38 == '0);
            len39_reg         <= len38;

            kcp        = k_reg * cmag39_reg;
            kc40_reg   <= kcp[63:16];
            cmag40_reg <= cmag39_reg;

            eh41_reg <= kc40_reg[47:24] * cmag40_reg;
            el41_reg <= kc40_reg[23:0] * cmag40_reg;

            esum = {eh41_reg, 24'd0} + {24'd0, el41_reg};
            energy42_reg <= (|esum[80:64]) ? {ENERGY_W{1'b1}} : esum[63:17];
        end
    end

    // ---------------------------- stages 39..55: direction components
    logic [UMAG_W-1:0] umag55 [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_dir
            segh_div #(.DEN_W(LEN_W), .Q_W(UMAG_W)) u_div_dir
            (
                .clk  (clk),
                .en   (en),
                .rem0 ({2'b00, dmag38[g][31:1]}),
                .num  ({dmag38[g][0], 16'd0}),
                .den  (len38),
                .quot (umag55[g])
            );
        end
    endgenerate

    logic [KC_W-1:0]  kc55, kc56_reg, kc57_reg;
    segh_flags_t      flags56;
    logic [LEN_W-1:0] len58;

    segh_delay #(.W(KC_W), .DEPTH(15)) u_dly_kc
    (
        .clk (clk), .en (en), .din (kc40_reg), .dout (kc55)
    );

    segh_delay #(.W($bits(segh_flags_t)), .DEPTH(17)) u_dly_flags_a
    (
        .clk (clk), .en (en), .din (flags39_reg), .dout (flags56)
    );

    segh_delay #(.W(LEN_W), .DEPTH(19)) u_dly_len
    (
        .clk (clk), .en (en), .din (len39_reg), .dout (len58)
    );

    // ----------------- stages 56..58: gradient, d*d^T and Hessian terms
    logic [64:0]        gp56_reg [3];
    logic [33:0]        dd56_reg [HESS_N];
    logic [OUT_W-1:0]   grad57_reg [3];
    logic [47:0]        t1p57_reg [HESS_N];
    logic [UMAG_W-1:0]  mmag57_reg [HESS_N];
    logic [HESS_N-1:0]  mneg57_reg, ddneg57_reg, mneg58_reg;
    logic [32:0]        t1s58_reg [HESS_N];
    logic [64:0]        n58_reg [HESS_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kc56_reg <= kc55;
            kc57_reg <= kc56_reg;
            for (int i = 0; i < 3; i++)
            begin
                gp56_reg[i]   <= kc55 * umag55[i];
                grad57_reg[i] <= enc48(flags56.cneg ^ flags56.dneg[i], gp56_reg[i][64:16]);
            end
            for (int h = 0; h < HESS_N; h++)
            begin
                logic [UMAG_W-1:0] ddm;
                logic              ddneg;
                dd56_reg[h] <= umag55[HESS_I[h]] * umag55[HESS_J[h]];

                ddm   = dd56_reg[h][32:16];
                ddneg = flags56.dneg[HESS_I[h]] ^ flags56.dneg[HESS_J[h]];
                ddneg57_reg[h] <= ddneg;
                t1p57_reg[h]   <= k_reg * ddm;
                if (HESS_I[h] == HESS_J[h])
                begin
                    mmag57_reg[h] <= 17'h10000 - ddm;
                    mneg57_reg[h] <= 1'b0;
                end
                else
                begin
                    mmag57_reg[h] <= ddm;
                    mneg57_reg[h] <= !ddneg && (ddm != '0);
                end

                t1s58_reg[h] <= ddneg57_reg[h] ? 33'd0 - {1'b0, t1p57_reg[h][47:16]}
                                               : {1'b0, t1p57_reg[h][47:16]};
                n58_reg[h]   <= kc57_reg * mmag57_reg[h];
            end
            mneg58_reg <= mneg57_reg;
        end
    end

    // --------------------------- stages 59..106: curvature term division
    logic [47:0]       q106 [HESS_N];
    logic [HESS_N-1:0] over58;
    logic [HESS_N*33-1:0] t1s58_flat, t1s106_flat;

    generate
        for (g = 0; g < HESS_N; g++)
        begin : g_hess
            // Quotients of 2^48 or more saturate the entry to the limit of its sign.
            assign over58[g] = ({16'd0, n58_reg[g][64:48]} >= len58);
            assign t1s58_flat[33*g +: 33] = t1s58_reg[g];

            segh_div #(.DEN_W(LEN_W), .Q_W(48)) u_div_hess
            (
                .clk  (clk),
                .en   (en),
                .rem0 ({16'd0, n58_reg[g][64:48]}),
                .num  (n58_reg[g][47:0]),
                .den  (len58),
                .quot (q106[g])
            );
        end
    endgenerate

    logic [HESS_N-1:0] over106, mneg106;
    segh_flags_t       flags106;
    logic [143:0]      grad106;
    logic [ENERGY_W-1:0] energy106;

    segh_delay #(.W(HESS_N*33 + 2*HESS_N), .DEPTH(48)) u_dly_hess
    (
        .clk  (clk),
        .en   (en),
        .din  ({over58, mneg58_reg, t1s58_flat}),
        .dout ({over106, mneg106, t1s106_flat})
    );

    segh_delay #(.W($bits(segh_flags_t)), .DEPTH(50)) u_dly_flags_b
    (
        .clk (clk), .en (en), .din (flags56), .dout (flags106)
    );

    segh_delay #(.W(144), .DEPTH(49)) u_dly_grad
    (
        .clk  (clk),
        .en   (en),
        .din  ({grad57_reg[2], grad57_reg[1], grad57_reg[0]}),
        .dout (grad106)
    );

    segh_delay #(.W(ENERGY_W), .DEPTH(64)) u_dly_energy
    (
        .clk (clk), .en (en), .din (energy42_reg), .dout (energy106)
    );

    // ---------------------------------- stage 107: output register
    logic [478:0] out_reg;
    logic         deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg[46:0]    <= energy106;
            out_reg[190:47]  <= flags106.deg ? 144'd0 : grad106;
            deg_reg          <= flags106.deg;
            for (int h = 0; h < HESS_N; h++)
            begin
                logic [50:0] t2u;
                logic [50:0] t2s;
                logic [50:0] hs;
                t2u = over106[h] ? 51'h1_0000_0000_0000 : {3'b000, q106[h]};
                t2s = (flags106.cneg ^ mneg106[h]) ? 51'd0 - t2u : t2u;
                hs  = {{18{t1s106_flat[33*h+32]}}, t1s106_flat[33*h +: 33]} + t2s;
                out_reg[191 + 48*h +: 48] <= flags106.deg ? 48'd0 : sat48($signed(hs));
            end
        end
    end

    assign m_tdata = {1'b0, out_reg};
    assign m_tuser = deg_reg;

endmodule

[hdl/segh_delay.sv]
// ============================================================================
// Delay line
// Stall-aware register chain that carries side data alongside a pipeline.
// ============================================================================
module segh_delay
    import segh_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

[hdl/segh_sqrt.sv]
// ============================================================================
// Pipelined square root
// Floor square root of a 66-bit value, one result bit per stage.
// ============================================================================
module segh_sqrt
    import segh_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [65:0]       radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int N   = ROOT_W;
    localparam int X_W = 2 * ROOT_W;
    localparam int R_W = ROOT_W + 2;

    logic [R_W-1:0]    rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic [X_W-1:0]    x_reg    [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [R_W-1:0] rem_prev;
            logic [N-1:0]   root_prev;
            logic [X_W-1:0] x_prev;
            logic [R_W+1:0] remsh;
            logic [R_W+1:0] trial;
            logic           ge;

            if (k == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign x_prev    = {{(X_W-66){1'b0}}, radicand};
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign x_prev    = x_reg[k-1];
            end

            always_comb
            begin
                remsh = {rem_prev, x_prev[X_W-1 -: 2]};
                trial = {1'b0, root_prev, 2'b01};
                ge    = (remsh >= trial);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? R_W'(remsh - trial) : R_W'(remsh);
                    root_reg[k] <= {root_prev[N-2:0], ge};
                    x_reg[k]    <= {x_prev[X_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule

[hdl/segh_div.sv]
// ============================================================================
// Pipelined divider
// Restoring division, one quotient bit per stage, for a dividend whose upper
// part is already below the divisor.
// ============================================================================
module segh_div
    import segh_pkg::*;
#(
    parameter int DEN_W = 33,
    parameter int Q_W   = 17
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem0,
    input  logic [Q_W-1:0]   num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   num_reg [Q_W];
    logic [Q_W-1:0]   q_reg   [Q_W];

    genvar s;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            logic [DEN_W-1:0] rem_prev;
            logic [DEN_W-1:0] den_prev;
            logic [Q_W-1:0]   num_prev;
            logic [Q_W-1:0]   q_prev;
            logic [DEN_W:0]   r2;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign rem_prev = rem0;
                assign den_prev = den;
                assign num_prev = num;
                assign q_prev   = '0;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[s-1];
                assign den_prev = den_reg[s-1];
                assign num_prev = num_reg[s-1];
                assign q_prev   = q_reg[s-1];
            end

            always_comb
            begin
                r2 = {rem_prev, num_prev[Q_W-1]};
                ge = (r2 >= {1'b0, den_prev});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? DEN_W'(r2 - {1'b0, den_prev}) : DEN_W'(r2);
                    den_reg[s] <= den_prev;
                    num_reg[s] <= {num_prev[Q_W-2:0], 1'b0};
                    q_reg[s]   <= {q_prev[Q_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quot = q_reg[Q_W-1];

endmodule

[hdl/segh_checker.sv]
// ============================================================================
// Port checker
// Assertions on the ports of the spring core, bound to its top level.
// ============================================================================
module segh_checker
    import segh_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic [479:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // The input only waits while a finished result is held back.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track the output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A zero-length spring carries no gradient or Hessian.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[478:47] == '0)
        else $error("degenerate spring with nonzero derivatives");

    // A stiffness write is seen on the read path in the next cycle.
    a_stiffness_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_STIFFNESS
        |=> prdata == {1'b0, $past(pwdata[30:0])} || paddr[2] != REG_STIFFNESS)
        else $error("stiffness register did not take the write");

endmodule

bind spring_energy_gradient_hessian_core segh_checker u_segh_checker (.*);
